FILE: rtl/ltei_pkg.sv
`default_nettype none
package ltei_pkg;
   localparam int CoordWidth = 16;
   localparam int ResultWidth = 32;
   localparam int DetWidth = 35;
   localparam int NumWidth = 64;
   localparam int QuotWidth = 34;
   localparam int DivStages = 34;
   // Mass divisor 24576 = 3 * 2^13: add half the divisor, drop 13 bits,
   // then divide by three with a reciprocal exact below 2^24
   localparam int MassRound = 12288;
   localparam int MassShift = 13;
   localparam int MassRecip = 11184811;
   localparam int MassRecipWidth = 24;
   localparam int MassRecipShift = 25;

   typedef logic [1:0] node_type;

   // Map node index three onto vertex two
   function automatic node_type clamp_node(input node_type n);
      return (n == 2'd3) ? 2'd2 : n;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/ltei_divider.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest (ties away from zero) and saturation to 32 bits signed.
module ltei_divider (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire logic                                   in_neg,
   input  wire logic [ltei_pkg::NumWidth-1:0]          in_num,
   input  wire logic [ltei_pkg::DetWidth-1:0]          in_den,
   output logic signed [ltei_pkg::ResultWidth-1:0]     out_quot
);
   import ltei_pkg::*;

   localparam int RemWidth = DetWidth + 2;
   localparam int NumExt = NumWidth + 1;
   localparam int SeedWidth = NumExt - QuotWidth;

   // Stage registers: numerator bits still to shift in, partial remainder,
   // quotient bits, divisor, sign and overflow travel together.
   logic [NumExt-1:0]    num_ff [DivStages+1];
   logic [RemWidth-1:0]  rem_ff [DivStages+1];
   logic [QuotWidth-1:0] quot_ff[DivStages+1];
   logic [RemWidth-1:0]  den_ff [DivStages+1];
   logic                 neg_ff [DivStages+1];
   logic                 ovf_ff [DivStages+1];
   logic [RemWidth-1:0]  rem_in [DivStages];
   logic [NumExt-1:0]    num_in [DivStages];
   logic [QuotWidth-1:0] quot_in[DivStages];
   logic [NumExt-1:0]    dividend;
   logic [RemWidth-1:0]  den_2x;
   logic [RemWidth-1:0]  seed;

   // Quotient of 2n+d over 2d: start from numerator 2n+d (fits in 65 bits),
   // long division over the low QuotWidth bits.
   // Seed remainder with the top NumExt-QuotWidth bits; a seed not below the
   // divisor means the quotient needs more than QuotWidth bits.
   always_comb begin
      dividend = ({1'b0, in_num} << 1) + NumExt'(in_den);
      den_2x   = {1'b0, in_den, 1'b0};
      seed     = RemWidth'(dividend[NumExt-1:QuotWidth]);
   end

   always_ff @(posedge clock) begin
      num_ff[0]  <= dividend << SeedWidth;
      rem_ff[0]  <= seed;
      quot_ff[0] <= '0;
      den_ff[0]  <= den_2x;
      neg_ff[0]  <= in_neg;
      ovf_ff[0]  <= (seed >= den_2x);
   end

   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      logic [RemWidth:0] trial;
      always_comb begin
         trial = {rem_ff[s], num_ff[s][NumExt-1]} - {1'b0, den_ff[s]};
         num_in[s] = num_ff[s] << 1;
         if (!trial[RemWidth]) begin
            rem_in[s]  = trial[RemWidth-1:0];
            quot_in[s] = {quot_ff[s][QuotWidth-2:0], 1'b1};
         end else begin
            rem_in[s]  = {rem_ff[s][RemWidth-2:0], num_ff[s][NumExt-1]};
            quot_in[s] = {quot_ff[s][QuotWidth-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         num_ff[s+1]  <= num_in[s];
         rem_ff[s+1]  <= rem_in[s];
         quot_ff[s+1] <= quot_in[s];
         den_ff[s+1]  <= den_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         ovf_ff[s+1]  <= ovf_ff[s];
      end
   end

   // Saturate and apply sign
   logic [QuotWidth-1:0] q;
   assign q = quot_ff[DivStages];
   always_comb begin
      if (neg_ff[DivStages]) begin
         if (ovf_ff[DivStages] || q > QuotWidth'(34'h080000000)) out_quot = 32'sh80000000;
         else out_quot = ResultWidth'(-q);
      end else begin
         if (ovf_ff[DivStages] || q > QuotWidth'(34'h07FFFFFFF)) out_quot = 32'sh7FFFFFFF;
         else out_quot = ResultWidth'(q);
      end
   end

   logic unused;
   assign unused = reset ^ in_valid ^ (^rem_ff[DivStages]) ^ (^num_ff[DivStages])
                   ^ (^den_ff[DivStages]);
endmodule
`default_nettype wire

FILE: rtl/linear_triangle_element_integrals.sv
`default_nettype none
// Pipeline: 3 front stages, the divider input register, 34 divider bit stages,
// then the output register, which drives rsp_valid.
// Throughput: one item per cycle; busy is tied low and every stage registers,
// so items may follow back to back.
// Reset (synchronous, active high) clears the valid bits only; results
// are shown for one cycle and the receiver cannot stall.
module linear_triangle_element_integrals (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [ltei_pkg::CoordWidth-1:0] req_vert0_x,
   input  wire logic signed [ltei_pkg::CoordWidth-1:0] req_vert0_y,
   input  wire logic signed [ltei_pkg::CoordWidth-1:0] req_vert1_x,
   input  wire logic signed [ltei_pkg::CoordWidth-1:0] req_vert1_y,
   input  wire logic signed [ltei_pkg::CoordWidth-1:0] req_vert2_x,
   input  wire logic signed [ltei_pkg::CoordWidth-1:0] req_vert2_y,
   input  wire logic [1:0]                          req_first_node,
   input  wire logic [1:0]                          req_second_node,
   output logic                                     rsp_valid,
   output logic signed [ltei_pkg::ResultWidth-1:0]  rsp_const_coef,
   output logic signed [ltei_pkg::ResultWidth-1:0]  rsp_x_coef,
   output logic signed [ltei_pkg::ResultWidth-1:0]  rsp_y_coef,
   output logic signed [ltei_pkg::ResultWidth-1:0]  rsp_stiffness_entry,
   output logic signed [ltei_pkg::ResultWidth-1:0]  rsp_mass_entry,
   output logic                                     rsp_degenerate
);
   import ltei_pkg::*;

   localparam int Lat = 3 + DivStages + 1;
   localparam int MsWidth = DetWidth + 1;
   localparam int MtWidth = MsWidth - MassShift;
   localparam int ProdWidth = MtWidth + MassRecipWidth;
   localparam int MqWidth = ProdWidth - MassRecipShift;

   assign busy = 1'b0;

   // Stage 1: pick node edges, edge vectors
   logic v1_ff;
   logic signed [16:0] bi_ff, ci_ff, bj_ff, cj_ff, e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [15:0] xp_ff, yp_ff, xq_ff, yq_ff;
   logic               same_ff;
   logic signed [15:0] vx[3], vy[3];
   node_type ni, nj, pi, qi, pj, qj;

   always_comb begin
      vx[0] = req_vert0_x; vx[1] = req_vert1_x; vx[2] = req_vert2_x;
      vy[0] = req_vert0_y; vy[1] = req_vert1_y; vy[2] = req_vert2_y;
      ni = clamp_node(req_first_node);
      nj = clamp_node(req_second_node);
      pi = (ni == 2'd2) ? 2'd0 : ni + 2'd1;
      qi = (ni == 2'd0) ? 2'd2 : ni - 2'd1;
      pj = (nj == 2'd2) ? 2'd0 : nj + 2'd1;
      qj = (nj == 2'd0) ? 2'd2 : nj - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      bi_ff  <= 17'(vy[pi]) - 17'(vy[qi]);
      ci_ff  <= 17'(vx[qi]) - 17'(vx[pi]);
      bj_ff  <= 17'(vy[pj]) - 17'(vy[qj]);
      cj_ff  <= 17'(vx[qj]) - 17'(vx[pj]);
      e1x_ff <= 17'(req_vert1_x) - 17'(req_vert0_x);
      e1y_ff <= 17'(req_vert1_y) - 17'(req_vert0_y);
      e2x_ff <= 17'(req_vert2_x) - 17'(req_vert0_x);
      e2y_ff <= 17'(req_vert2_y) - 17'(req_vert0_y);
      xp_ff <= vx[pi]; yp_ff <= vy[pi]; xq_ff <= vx[qi]; yq_ff <= vy[qi];
      same_ff <= (ni == nj);
   end

   // Stage 2: products
   logic v2_ff, same2_ff;
   logic signed [33:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [31:0] a1_ff, a2_ff;
   logic signed [16:0] bi2_ff, ci2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      m1_ff <= 34'(e1x_ff * e2y_ff);
      m2_ff <= 34'(e2x_ff * e1y_ff);
      m3_ff <= 34'(bi_ff * bj_ff);
      m4_ff <= 34'(ci_ff * cj_ff);
      a1_ff <= xp_ff * yq_ff;
      a2_ff <= xq_ff * yp_ff;
      bi2_ff <= bi_ff; ci2_ff <= ci_ff; same2_ff <= same_ff;
   end

   // Stage 3: determinant, magnitudes and signs for the dividers
   logic v3_ff;
   logic [DetWidth-1:0] det_mag_ff;
   logic degen_ff, same3_ff;
   logic n_c0_ff, n_cx_ff, n_cy_ff, n_st_ff;
   logic [NumWidth-1:0] num_c0_ff, num_cx_ff, num_cy_ff, num_st_ff;
   logic [MsWidth-1:0] num_ms_ff;
   logic signed [DetWidth-1:0] det;
   logic signed [32:0] ai;
   logic signed [34:0] dot;
   always_comb begin
      det = 35'(m1_ff) - 35'(m2_ff);
      ai  = 33'(a1_ff) - 33'(a2_ff);
      dot = 35'(m3_ff) + 35'(m4_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      degen_ff   <= (det == '0);
      det_mag_ff <= det[DetWidth-1] ? DetWidth'(-det) : DetWidth'(det);
      n_c0_ff <= (ai != '0) && (ai[32] != det[DetWidth-1]);
      n_cx_ff <= (bi2_ff != '0) && (bi2_ff[16] != det[DetWidth-1]);
      n_cy_ff <= (ci2_ff != '0) && (ci2_ff[16] != det[DetWidth-1]);
      n_st_ff <= dot[34];
      num_c0_ff <= NumWidth'(ai[32] ? -ai : ai) << 16;
      num_cx_ff <= NumWidth'(bi2_ff[16] ? -bi2_ff : bi2_ff) << 29;
      num_cy_ff <= NumWidth'(ci2_ff[16] ? -ci2_ff : ci2_ff) << 29;
      num_st_ff <= NumWidth'(dot[34] ? -dot : dot) << 15;
      num_ms_ff <= MsWidth'(det[DetWidth-1] ? -det : det) << same2_ff;
      same3_ff <= same2_ff;
   end

   // Dividers
   logic signed [ResultWidth-1:0] q_c0, q_cx, q_cy, q_st;
   ltei_divider u_div_c0 (.clock, .reset, .in_valid(v3_ff), .in_neg(n_c0_ff),
      .in_num(num_c0_ff), .in_den(det_mag_ff), .out_quot(q_c0));
   ltei_divider u_div_cx (.clock, .reset, .in_valid(v3_ff), .in_neg(n_cx_ff),
      .in_num(num_cx_ff), .in_den(det_mag_ff), .out_quot(q_cx));
   ltei_divider u_div_cy (.clock, .reset, .in_valid(v3_ff), .in_neg(n_cy_ff),
      .in_num(num_cy_ff), .in_den(det_mag_ff), .out_quot(q_cy));
   ltei_divider u_div_st (.clock, .reset, .in_valid(v3_ff), .in_neg(n_st_ff),
      .in_num(num_st_ff), .in_den(det_mag_ff), .out_quot(q_st));

   // Mass entry: add half of 24576, drop 13 bits, divide by three by
   // reciprocal multiplication, then delay to line up with the dividers
   logic [MtWidth-1:0]                ms_t_ff;
   logic [MqWidth-1:0]                ms_q_ff;
   logic [DivStages-2:0][MqWidth-1:0] ms_dly_ff;
   logic [ProdWidth-1:0]              ms_prod;
   assign ms_prod = ProdWidth'(ms_t_ff) * ProdWidth'(MassRecip);
   always_ff @(posedge clock) begin
      ms_t_ff   <= MtWidth'((num_ms_ff + MsWidth'(MassRound)) >> MassShift);
      ms_q_ff   <= MqWidth'(ms_prod >> MassRecipShift);
      ms_dly_ff <= {ms_dly_ff[DivStages-3:0], ms_q_ff};
   end

   // Carry valid and degenerate flag alongside the divider stages
   logic [DivStages:0] vd_ff, dg_ff;
   always_ff @(posedge clock) begin
      if (reset) vd_ff <= '0;
      else vd_ff <= {vd_ff[DivStages-1:0], v3_ff};
      dg_ff <= {dg_ff[DivStages-1:0], degen_ff};
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= vd_ff[DivStages];
      rsp_degenerate      <= dg_ff[DivStages];
      rsp_const_coef      <= dg_ff[DivStages] ? '0 : q_c0;
      rsp_x_coef          <= dg_ff[DivStages] ? '0 : q_cx;
      rsp_y_coef          <= dg_ff[DivStages] ? '0 : q_cy;
      rsp_stiffness_entry <= dg_ff[DivStages] ? '0 : q_st;
      rsp_mass_entry      <= dg_ff[DivStages] ? '0 : ResultWidth'(ms_dly_ff[DivStages-2]);
   end

   logic unused;
   assign unused = same3_ff ^ (Lat == 0);
endmodule
`default_nettype wire

FILE: rtl/ltei_checker.sv
`default_nettype none
module ltei_assert (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_degenerate,
   input wire logic [31:0] rsp_const_coef,
   input wire logic [31:0] rsp_mass_entry
);
   // Never refuse an item
   a_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
   // Degenerate results carry zero values
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_const_coef == '0 && rsp_mass_entry == '0)
      else $error("degenerate result nonzero");
   // Mass entry is never negative
   a_mass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_mass_entry[31]) else $error("negative mass");
   // No result right after reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind linear_triangle_element_integrals ltei_assert u_ltei_assert (
   .clock, .reset, .busy, .rsp_valid, .rsp_degenerate, .rsp_const_coef,
   .rsp_mass_entry);
`default_nettype wire

FILE: tb/ltei_checker.sv
module ltei_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic signed [15:0] req_vert0_x,
   input  wire logic signed [15:0] req_vert0_y,
   input  wire logic signed [15:0] req_vert1_x,
   input  wire logic signed [15:0] req_vert1_y,
   input  wire logic signed [15:0] req_vert2_x,
   input  wire logic signed [15:0] req_vert2_y,
   input  wire logic [1:0]  req_first_node,
   input  wire logic [1:0]  req_second_node,
   input  wire logic        rsp_valid,
   input  wire logic signed [31:0] rsp_const_coef,
   input  wire logic signed [31:0] rsp_x_coef,
   input  wire logic signed [31:0] rsp_y_coef,
   input  wire logic signed [31:0] rsp_stiffness_entry,
   input  wire logic signed [31:0] rsp_mass_entry,
   input  wire logic        rsp_degenerate,
   output int               errors,
   output int               pending
);
   typedef struct packed {
      logic signed [31:0] const_coef;
      logic signed [31:0] x_coef;
      logic signed [31:0] y_coef;
      logic signed [31:0] stiffness;
      logic signed [31:0] mass;
      logic               degenerate;
   } element_type;

   element_type expected_elements[$];

   // Round to nearest with ties away from zero, then saturate to 32 bits
   function automatic logic signed [31:0] round_div(input longint num, input longint den);
      longint n, d, q;
      logic   neg;
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      neg = ((num < 0) != (den < 0)) && (n != 0);
      q = (2 * n + d) / (2 * d);
      if (neg) begin
         if (q > 64'sd2147483648) q = 64'sd2147483648;
         return 32'(-q);
      end
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      return 32'(q);
   endfunction

   function automatic element_type integrate_element(input longint xs[3], input longint ys[3],
                                                     input logic [1:0] ni_raw,
                                                     input logic [1:0] nj_raw);
      element_type r;
      int       ni, nj, pi, qi, pj, qj;
      longint   det, adet, bi, ci, bj, cj, ai;
      r = '0;
      ni = (ni_raw == 2'd3) ? 2 : ni_raw;
      nj = (nj_raw == 2'd3) ? 2 : nj_raw;
      det = (xs[1] - xs[0]) * (ys[2] - ys[0]) - (xs[2] - xs[0]) * (ys[1] - ys[0]);
      if (det == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      pi = (ni + 1) % 3;
      qi = (ni + 2) % 3;
      pj = (nj + 1) % 3;
      qj = (nj + 2) % 3;
      bi = ys[pi] - ys[qi];
      ci = xs[qi] - xs[pi];
      bj = ys[pj] - ys[qj];
      cj = xs[qj] - xs[pj];
      ai = xs[pi] * ys[qi] - xs[qi] * ys[pi];
      adet = (det < 0) ? -det : det;
      r.const_coef = round_div(ai * 65536, det);
      r.x_coef = round_div(bi * (64'sd1 <<< 29), det);
      r.y_coef = round_div(ci * (64'sd1 <<< 29), det);
      r.stiffness = round_div((bi * bj + ci * cj) * 32768, adet);
      r.mass = round_div(adet * ((ni == nj) ? 2 : 1), 24576);
      return r;
   endfunction

   // Predict on every accepted item
   always @(posedge clock) begin
      longint xs[3], ys[3];
      if (!reset && start && !busy) begin
         xs[0] = req_vert0_x; ys[0] = req_vert0_y;
         xs[1] = req_vert1_x; ys[1] = req_vert1_y;
         xs[2] = req_vert2_x; ys[2] = req_vert2_y;
         expected_elements.push_back(integrate_element(xs, ys, req_first_node,
                                                       req_second_node));
      end
   end

   // Compare each result with the oldest prediction
   initial errors = 0;
   always @(posedge clock) begin
      element_type exp_e, act_e;
      if (!reset && rsp_valid) begin
         act_e = {rsp_const_coef, rsp_x_coef, rsp_y_coef, rsp_stiffness_entry,
                  rsp_mass_entry, rsp_degenerate};
         if (expected_elements.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", act_e);
         end else begin
            exp_e = expected_elements.pop_front();
            if (exp_e !== act_e) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: c0 %0d/%0d cx %0d/%0d cy %0d/%0d",
                            " k %0d/%0d m %0d/%0d dg %0b/%0b"},
                           exp_e.const_coef, act_e.const_coef, exp_e.x_coef, act_e.x_coef,
                           exp_e.y_coef, act_e.y_coef, exp_e.stiffness, act_e.stiffness,
                           exp_e.mass, act_e.mass, exp_e.degenerate, act_e.degenerate);
            end
         end
      end
   end

   // Publish the count of items still in flight
   initial pending = 0;
   always @(negedge clock) pending <= expected_elements.size();
endmodule

FILE: tb/tb.sv
module tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic signed [15:0] vx[3], vy[3];
   logic [1:0]  first_node = '0, second_node = '0;
   logic        rsp_valid, rsp_degenerate;
   logic signed [31:0] rsp_const_coef, rsp_x_coef, rsp_y_coef, rsp_stiffness_entry,
                       rsp_mass_entry;
   int          errors, pending;

   initial begin
      for (int k = 0; k < 3; k++) begin
         vx[k] = '0;
         vy[k] = '0;
      end
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   linear_triangle_element_integrals u_top (
      .clock, .reset, .start, .busy,
      .req_vert0_x(vx[0]), .req_vert0_y(vy[0]), .req_vert1_x(vx[1]),
      .req_vert1_y(vy[1]), .req_vert2_x(vx[2]), .req_vert2_y(vy[2]),
      .req_first_node(first_node), .req_second_node(second_node),
      .rsp_valid, .rsp_const_coef, .rsp_x_coef, .rsp_y_coef, .rsp_stiffness_entry,
      .rsp_mass_entry, .rsp_degenerate
   );

   ltei_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_vert0_x(vx[0]), .req_vert0_y(vy[0]), .req_vert1_x(vx[1]),
      .req_vert1_y(vy[1]), .req_vert2_x(vx[2]), .req_vert2_y(vy[2]),
      .req_first_node(first_node), .req_second_node(second_node),
      .rsp_valid, .rsp_const_coef, .rsp_x_coef, .rsp_y_coef, .rsp_stiffness_entry,
      .rsp_mass_entry, .rsp_degenerate, .errors, .pending
   );

   // Hold start low for a random gap, then offer one triangle until accepted
   task automatic send_triangle(input int x0, y0, x1, y1, x2, y2, input int i, j);
      int  gap;
      bit  taken;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      vx[0] <= 16'(x0); vy[0] <= 16'(y0);
      vx[1] <= 16'(x1); vy[1] <= 16'(y1);
      vx[2] <= 16'(x2); vy[2] <= 16'(y2);
      first_node <= 2'(i);
      second_node <= 2'(j);
      start <= 1'b1;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      repeat (2) @(negedge clock);
      wait (pending == 0);
      repeat (50) @(posedge clock);
   endtask

   function automatic int near(input int base, input int span);
      int v;
      v = base + $urandom_range(0, 2 * span) - span;
      return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
   endfunction

   initial begin
      int x0, y0, x1, y1, x2, y2, k, kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every node pair on a unit triangle, node index three
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 3; j++)
            send_triangle(0, 0, 8192, 0, 0, 8192, i, j);
      send_triangle(0, 0, 8192, 0, 0, 8192, 3, 3);
      // Extremes of the coordinates, both windings
      send_triangle(-32768, -32768, 32767, -32768, -32768, 32767, 0, 1);
      send_triangle(-32768, -32768, -32768, 32767, 32767, -32768, 2, 2);
      send_triangle(32767, 32767, -32768, 32767, 32767, -32768, 1, 0);
      // Zero determinant: a point and a collinear set
      send_triangle(5, 5, 5, 5, 5, 5, 0, 0);
      send_triangle(-100, -100, 0, 0, 100, 100, 1, 2);
      // Near-degenerate triangles: thin slivers and a tiny one
      send_triangle(-32768, 0, 32767, 1, 32767, 0, 0, 0);
      send_triangle(32767, -32768, 0, 0, 32767, -32767, 1, 1);
      send_triangle(0, 0, 1, 0, 0, 1, 2, 0);

      for (int n = 0; n < 1550; n++) begin
         if (n == 700) drain_results();
         kind = $urandom_range(0, 9);
         x0 = $signed(16'($urandom)); y0 = $signed(16'($urandom));
         if (kind < 6) begin
            x1 = $signed(16'($urandom)); y1 = $signed(16'($urandom));
            x2 = $signed(16'($urandom)); y2 = $signed(16'($urandom));
         end else if (kind < 8) begin
            // Thin or tiny triangles
            x1 = near(x0, 300); y1 = near(y0, 300);
            x2 = near(x1, 3); y2 = near(y1, 3);
         end else begin
            // Collinear vertices
            x1 = near(x0, 100); y1 = near(y0, 100);
            k = $urandom_range(0, 2);
            x2 = x0 + k * (x1 - x0); y2 = y0 + k * (y1 - y0);
            if (x2 > 32767 || x2 < -32768 || y2 > 32767 || y2 < -32768) begin
               x2 = x1; y2 = y1;
            end
         end
         send_triangle(x0, y0, x1, y1, x2, y2, $urandom_range(0, 3), $urandom_range(0, 3));
      end

      drain_results();
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Bound the run
   initial begin
      #(12 * 400000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

FILE: files.f
rtl/ltei_pkg.sv
rtl/ltei_divider.sv
rtl/linear_triangle_element_integrals.sv
rtl/ltei_checker.sv
tb/ltei_checker.sv
tb/tb.sv
